/* design/omni_pkg.sv */
// Types, codes and the quarter-sine table builder for the omni drive mixer.
package omni_pkg;

    localparam int TRIG_FRAC_DEFAULT = 14;
    localparam int TRIG_FRAC_MAX     = 16;
    localparam int QS_W              = TRIG_FRAC_MAX + 1;
    localparam int QS_DEPTH          = 91;
    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [7:0] SERIES_DIV [1:7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156,
                                                8'd210};

    localparam int IN_W   = 72;
    localparam int OUT_W  = 40;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 8;

    // reciprocal multipliers for truncating division by 180 and 178
    localparam logic [17:0] RECIP_180 = 18'd186414;
    localparam logic [17:0] RECIP_178 = 18'd188509;
    localparam int RECIP_SHIFT        = 25;

    typedef logic [QS_W-1:0] qsin_tab_t [0:QS_DEPTH-1];

    typedef enum logic [1:0] {
        OP_DRIVE = 2'd0,
        OP_RAW   = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        SEC_NONE  = 2'd0,
        SEC_LEFT  = 2'd1,
        SEC_RIGHT = 2'd2
    } sec_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_M1_SIGN   = 3'd0,
        CFG_M2_SIGN   = 3'd1,
        CFG_M3_SIGN   = 3'd2,
        CFG_M4_SIGN   = 3'd3,
        CFG_TOLERANCE = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic       neg;
        logic [6:0] k;
    } angle_t;

    typedef struct packed {
        logic [7:0] duty;
        logic       rev;
    } enc_t;

    function automatic qsin_tab_t build_qsin(input int frac);
        qsin_tab_t   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] sum;
        logic [63:0] t;
        for (int k = 0; k < QS_DEPTH; k++)
        begin
            x   = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
            x2  = (x * x) >> 30;
            sum = x;
            t   = x;
            for (int n = 1; n <= 7; n++)
            begin
                t = ((t * x2) >> 30) / 64'(SERIES_DIV[n]);
                if (n % 2 == 1)
                    sum = sum - t;
                else
                    sum = sum + t;
            end
            tab[k] = QS_W'((sum + (64'd1 << (29 - frac))) >> (30 - frac));
        end
        return tab;
    endfunction

    function automatic angle_t reduce_angle(input logic [9:0] a);
        angle_t     r;
        logic [9:0] d;
        d = (a >= 10'd360) ? (a - 10'd360) : a;
        if (d <= 10'd90)
        begin
            r.neg = 1'b0;
            r.k   = d[6:0];
        end
        else if (d <= 10'd180)
        begin
            r.neg = 1'b0;
            r.k   = 7'(10'd180 - d);
        end
        else if (d <= 10'd270)
        begin
            r.neg = 1'b1;
            r.k   = 7'(d - 10'd180);
        end
        else
        begin
            r.neg = 1'b1;
            r.k   = 7'(10'd360 - d);
        end
        return r;
    endfunction

    function automatic logic [7:0] clamp_gain(input logic signed [11:0] v,
                                              input logic [7:0] gain);
        logic [7:0] r;
        if (v < 12'sd0)
            r = 8'd0;
        else if (v > signed'({4'b0, gain}))
            r = gain;
        else
            r = v[7:0];
        return r;
    endfunction

    function automatic enc_t encode(input logic signed [11:0] m, input logic signed [1:0] sgn);
        enc_t               e;
        logic signed [13:0] v;
        logic [13:0]        mag;
        logic [7:0]         sat;
        v   = signed'({{2{m[11]}}, m}) * signed'({{12{sgn[1]}}, sgn});
        mag = v[13] ? 14'(-v) : 14'(v);
        sat = (mag > 14'd255) ? 8'd255 : mag[7:0];
        e.rev  = v[13];
        e.duty = v[13] ? (8'd255 - sat) : sat;
        return e;
    endfunction

endpackage

/* design/omni_drive_mixer.sv */
// Five-stage omni drive mixer: drive command in, four motor direction/duty pairs out.
//
// Usage: input words arrive on the s_axis channel and one result word per input leaves
// on the m_axis channel, in order. A word is taken when tvalid and tready are both high.
// Opcode 0 drives at a travel angle with compass heading correction, opcode 1 passes
// raw motor commands, opcode 2 (and the unused code) stops all motors.
// Configuration is a write-only port: cfg_we, cfg_addr and cfg_wdata; write only
// while no word is in flight. Registers: four motor signs, heading tolerance.
// The word passes through stage registers 1 to 5 in order before m_axis_tvalid rises.
// Throughput: one word per cycle while the receiver keeps up; each stage holds one word.
// The sine table and reciprocal dividers are in stage 2, the speed multiplier in stage 3.
// Reset clears all stage valid bits and sets signs to 1 and tolerance to 5.
// When the receiver stalls, each stage holds its word and the pipeline keeps
// filling its empty stages, so s_axis_tready drops only when all five are full.
module omni_drive_mixer #(
    parameter int TRIG_FRAC_BITS = omni_pkg::TRIG_FRAC_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // opcode, travel_angle, speed, turn_gain_max, compass_heading,
    // raw_motor1, raw_motor2, raw_motor3, raw_motor4
    input  logic [omni_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // motor1_reverse, motor1_duty, motor2_reverse, motor2_duty, motor3_reverse,
    // motor3_duty, motor4_reverse, motor4_duty, zero pad
    output logic [omni_pkg::OUT_W-1:0]    m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [omni_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [omni_pkg::CFG_DW-1:0]   cfg_wdata
);

    localparam int TW = TRIG_FRAC_BITS + 1;
    localparam int PW = TW + 8;
    localparam omni_pkg::qsin_tab_t QSIN = omni_pkg::build_qsin(TRIG_FRAC_BITS);

    logic signed [1:0] sign_reg [4];
    logic [7:0]        tol_reg;

    logic              vld_reg [1:5];
    logic              rdy     [1:5];

    // stage 1
    omni_pkg::op_t      op1_reg;
    omni_pkg::sec_t     sec1_reg;
    logic [7:0]         spd1_reg;
    logic [7:0]         gain1_reg;
    logic [6:0]         k1_reg   [2];
    logic               neg1_reg [2];
    logic signed [19:0] pl1_reg;
    logic signed [19:0] pr1_reg;
    logic signed [8:0]  raw1_reg [4];

    // stage 2
    omni_pkg::op_t      op2_reg;
    omni_pkg::sec_t     sec2_reg;
    logic [7:0]         spd2_reg;
    logic [7:0]         gain2_reg;
    logic [TW-1:0]      tv2_reg  [2];
    logic               neg2_reg [2];
    logic [9:0]         ql2_reg;
    logic [9:0]         qr2_reg;
    logic               qln2_reg;
    logic               qrn2_reg;
    logic signed [8:0]  raw2_reg [4];

    // stage 3
    omni_pkg::op_t      op3_reg;
    omni_pkg::sec_t     sec3_reg;
    logic signed [9:0]  v3_reg   [2];
    logic [7:0]         lc3_reg;
    logic [7:0]         rc3_reg;
    logic signed [8:0]  raw3_reg [4];

    // stage 4
    logic signed [11:0] m4_reg   [4];

    // stage 5
    omni_pkg::enc_t     enc5_reg [4];

    // input unpack
    logic [1:0]         in_op;
    logic [8:0]         in_ang;
    logic [7:0]         in_spd;
    logic [7:0]         in_gain;
    logic [8:0]         in_cmp;
    logic signed [8:0]  in_raw [4];

    assign in_op   = s_axis_tdata[1:0];
    assign in_ang  = s_axis_tdata[10:2];
    assign in_spd  = s_axis_tdata[18:11];
    assign in_gain = s_axis_tdata[26:19];
    assign in_cmp  = s_axis_tdata[35:27];
    assign in_raw[0] = s_axis_tdata[44:36];
    assign in_raw[1] = s_axis_tdata[53:45];
    assign in_raw[2] = s_axis_tdata[62:54];
    assign in_raw[3] = s_axis_tdata[71:63];

    // handshake chain
    always_comb
    begin
        rdy[5] = !vld_reg[5] || m_axis_tready;
        for (int i = 4; i >= 1; i--)
            rdy[i] = !vld_reg[i] || rdy[i+1];
    end

    assign s_axis_tready = rdy[1];
    assign m_axis_tvalid = vld_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 5; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            if (rdy[1])
                vld_reg[1] <= s_axis_tvalid;
            for (int i = 2; i <= 5; i++)
                if (rdy[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                sign_reg[i] <= 2'sd1;
            tol_reg <= 8'd5;
        end
        else if (cfg_we)
        begin
            unique case (omni_pkg::cfg_idx_t'(cfg_addr))
                omni_pkg::CFG_M1_SIGN:   sign_reg[0] <= cfg_wdata[1:0];
                omni_pkg::CFG_M2_SIGN:   sign_reg[1] <= cfg_wdata[1:0];
                omni_pkg::CFG_M3_SIGN:   sign_reg[2] <= cfg_wdata[1:0];
                omni_pkg::CFG_M4_SIGN:   sign_reg[3] <= cfg_wdata[1:0];
                omni_pkg::CFG_TOLERANCE: tol_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage 1: angle reduction, heading products, sector
    omni_pkg::angle_t   ax;
    omni_pkg::angle_t   ay;
    logic signed [19:0] pl_next;
    logic signed [19:0] pr_next;
    omni_pkg::sec_t     sec_next;
    logic [8:0]         tol_hi;

    always_comb
    begin
        ax      = omni_pkg::reduce_angle({1'b0, in_ang} + 10'd130);
        ay      = omni_pkg::reduce_angle({1'b0, in_ang} + 10'd50);
        pl_next = signed'({11'b0, in_cmp}) * (signed'({12'b0, in_gain}) - 20'sd5);
        pr_next = (signed'({11'b0, in_cmp}) - 20'sd181)
                  * (20'sd5 - signed'({12'b0, in_gain}));
        tol_hi  = 9'd360 - {1'b0, tol_reg};
        if (in_cmp > {1'b0, tol_reg} && in_cmp <= 9'd180)
            sec_next = omni_pkg::SEC_LEFT;
        else if (in_cmp > 9'd180 && in_cmp < tol_hi)
            sec_next = omni_pkg::SEC_RIGHT;
        else
            sec_next = omni_pkg::SEC_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            op1_reg     <= omni_pkg::op_t'(in_op);
            sec1_reg    <= sec_next;
            spd1_reg    <= in_spd;
            gain1_reg   <= in_gain;
            k1_reg[0]   <= ax.k;
            neg1_reg[0] <= ax.neg;
            k1_reg[1]   <= ay.k;
            neg1_reg[1] <= ay.neg;
            pl1_reg     <= pl_next;
            pr1_reg     <= pr_next;
            for (int i = 0; i < 4; i++)
                raw1_reg[i] <= in_raw[i];
        end
    end

    // stage 2: sine lookup, reciprocal division
    logic [16:0] al;
    logic [16:0] ar;
    logic [34:0] ql_prod;
    logic [34:0] qr_prod;

    always_comb
    begin
        al      = pl1_reg[19] ? 17'(-pl1_reg) : 17'(pl1_reg);
        ar      = pr1_reg[19] ? 17'(-pr1_reg) : 17'(pr1_reg);
        ql_prod = 35'(al) * 35'(omni_pkg::RECIP_180);
        qr_prod = 35'(ar) * 35'(omni_pkg::RECIP_178);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            op2_reg   <= op1_reg;
            sec2_reg  <= sec1_reg;
            spd2_reg  <= spd1_reg;
            gain2_reg <= gain1_reg;
            for (int j = 0; j < 2; j++)
            begin
                tv2_reg[j]  <= QSIN[k1_reg[j]][TW-1:0];
                neg2_reg[j] <= neg1_reg[j];
            end
            ql2_reg  <= ql_prod[omni_pkg::RECIP_SHIFT +: 10];
            qr2_reg  <= qr_prod[omni_pkg::RECIP_SHIFT +: 10];
            qln2_reg <= pl1_reg[19];
            qrn2_reg <= pr1_reg[19];
            for (int i = 0; i < 4; i++)
                raw2_reg[i] <= raw1_reg[i];
        end
    end

    // stage 3: speed scaling, rounding, heading clamp
    logic [PW-1:0]      sprod [2];
    logic [7:0]         rmag  [2];
    logic signed [9:0]  v_next [2];
    logic signed [11:0] ql_s;
    logic signed [11:0] qr_s;

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            sprod[j] = PW'(tv2_reg[j]) * PW'(spd2_reg)
                       + (PW'(1) << (TRIG_FRAC_BITS - 1));
            rmag[j]  = sprod[j][TRIG_FRAC_BITS +: 8];
            if (rmag[j] != 8'd0 && rmag[j] < 8'd10)
                rmag[j] = 8'd10;
            v_next[j] = neg2_reg[j] ? -signed'({2'b0, rmag[j]}) : signed'({2'b0, rmag[j]});
        end
        ql_s = qln2_reg ? -signed'({2'b0, ql2_reg}) : signed'({2'b0, ql2_reg});
        qr_s = qrn2_reg ? -signed'({2'b0, qr2_reg}) : signed'({2'b0, qr2_reg});
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            op3_reg  <= op2_reg;
            sec3_reg <= sec2_reg;
            for (int j = 0; j < 2; j++)
                v3_reg[j] <= v_next[j];
            lc3_reg <= omni_pkg::clamp_gain(ql_s + 12'sd5, gain2_reg);
            rc3_reg <= omni_pkg::clamp_gain(qr_s + signed'({4'b0, gain2_reg}), gain2_reg);
            for (int i = 0; i < 4; i++)
                raw3_reg[i] <= raw2_reg[i];
        end
    end

    // stage 4: wheel mixing and opcode select
    logic signed [11:0] vx;
    logic signed [11:0] vy;
    logic signed [11:0] lc;
    logic signed [11:0] rc;
    logic signed [11:0] m_next [4];

    always_comb
    begin
        vx = {{2{v3_reg[0][9]}}, v3_reg[0]};
        vy = {{2{v3_reg[1][9]}}, v3_reg[1]};
        lc = signed'({4'b0, lc3_reg});
        rc = signed'({4'b0, rc3_reg});
        unique case (op3_reg)
            omni_pkg::OP_DRIVE:
            begin
                unique case (sec3_reg)
                    omni_pkg::SEC_LEFT:
                    begin
                        m_next[0] = vx + lc;
                        m_next[1] = vy + lc;
                        m_next[2] = vx - ((lc <<< 1) + lc);
                        m_next[3] = vy - ((lc <<< 1) + lc);
                    end
                    omni_pkg::SEC_RIGHT:
                    begin
                        m_next[0] = vx - ((rc <<< 1) + rc);
                        m_next[1] = vy - ((rc <<< 1) + rc);
                        m_next[2] = vx + rc;
                        m_next[3] = vy + rc;
                    end
                    default:
                    begin
                        m_next[0] = vx;
                        m_next[1] = vy;
                        m_next[2] = vx;
                        m_next[3] = vy;
                    end
                endcase
            end
            omni_pkg::OP_RAW:
            begin
                for (int i = 0; i < 4; i++)
                    m_next[i] = {{3{raw3_reg[i][8]}}, raw3_reg[i]};
            end
            default:
            begin
                for (int i = 0; i < 4; i++)
                    m_next[i] = 12'sd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            for (int i = 0; i < 4; i++)
                m4_reg[i] <= m_next[i];
        end
    end

    // stage 5: sign, saturate, encode
    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            for (int i = 0; i < 4; i++)
                enc5_reg[i] <= omni_pkg::encode(m4_reg[i], sign_reg[i]);
        end
    end

    assign m_axis_tdata = {4'b0, enc5_reg[3], enc5_reg[2], enc5_reg[1], enc5_reg[0]};

endmodule
